@@ hdl/rbc_pkg.sv @@
`timescale 1ns / 1ps

package rbc_pkg;

  // Field and register widths
  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned DATA_W      = 8;
  localparam int unsigned OFFSET_W    = 21;
  localparam int unsigned BANK_W      = 7;
  localparam int unsigned BANK_LO_W   = 5;
  localparam int unsigned SIZE_W      = 3;
  localparam int unsigned BANK_SHIFT  = 14;      // 16 KB banks
  localparam int unsigned CFG_DATA_W  = 3;
  localparam int unsigned CFG_INDEX_W = 1;

  // Stream widths, padded to whole bytes
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 24;

  localparam int unsigned ROM_OFFSET_BITS_DEF = 21;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_ROM_SIZE  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BOOT_VIS  = 1'b1;

  // Access kinds
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // ROM size codes
  localparam logic [SIZE_W-1:0] SIZE_64K  = 3'd1;
  localparam logic [SIZE_W-1:0] SIZE_128K = 3'd2;
  localparam logic [SIZE_W-1:0] SIZE_256K = 3'd3;
  localparam logic [SIZE_W-1:0] SIZE_1M   = 3'd5;
  localparam logic [SIZE_W-1:0] SIZE_2M   = 3'd6;

  localparam logic [ADDR_W-1:0] BOOT_END = 16'h0100;

  // Address regions of the cartridge ROM window
  typedef enum logic [2:0] {
    RGN_ROM0,     // 0x0000-0x1FFF
    RGN_BANK_LO,  // 0x2000-0x3FFF
    RGN_BANK_HI,  // 0x4000-0x5FFF
    RGN_MODE,     // 0x6000-0x7FFF
    RGN_OUTSIDE   // 0x8000 and above
  } region_t;

  // Bank state shared between update and mapping logic
  typedef struct packed {
    logic [BANK_W-1:0] rom_bank;
    logic [BANK_W-1:0] zero_area_bank;
    logic              bank_mode;
  } bank_state_t;

  function automatic region_t addr_region(input logic [ADDR_W-1:0] addr);
    region_t r;
    if (addr[15]) begin
      r = RGN_OUTSIDE;
    end else begin
      case (addr[14:13])
        2'd0:    r = RGN_ROM0;
        2'd1:    r = RGN_BANK_LO;
        2'd2:    r = RGN_BANK_HI;
        default: r = RGN_MODE;
      endcase
    end
    return r;
  endfunction

endpackage

@@ hdl/rbc_bank_regs.sv @@
`timescale 1ns / 1ps

module rbc_bank_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [rbc_pkg::SIZE_W-1:0]   rom_size_code,
  input  logic                         update,
  input  logic                         func,
  input  logic [rbc_pkg::ADDR_W-1:0]   bus_address,
  input  logic [rbc_pkg::DATA_W-1:0]   write_data,
  output rbc_pkg::bank_state_t         state
);
  import rbc_pkg::*;

  bank_state_t state_next;
  logic [BANK_LO_W-1:0] lo_mask;
  logic [BANK_LO_W-1:0] lo_bits;
  logic [1:0]           up_bits;

  // Select low-bank mask by ROM size
  always_comb begin
    case (rom_size_code)
      SIZE_64K:  lo_mask = 5'h03;
      SIZE_128K: lo_mask = 5'h07;
      SIZE_256K: lo_mask = 5'h0F;
      default:   lo_mask = 5'h1F;
    endcase
  end

  // Map zero to bank one; otherwise mask
  assign lo_bits = (write_data[BANK_LO_W-1:0] == '0) ? 5'h01
                                                   : (write_data[BANK_LO_W-1:0] & lo_mask);

  // Upper bank bits exist only from 1 MB up; the second one only from 2 MB up
  always_comb begin
    if (rom_size_code < SIZE_1M) begin
      up_bits = 2'b00;
    end else if (rom_size_code < SIZE_2M) begin
      up_bits = {1'b0, write_data[0]};
    end else begin
      up_bits = write_data[1:0];
    end
  end

  // Compute next bank state for a write
  always_comb begin
    state_next = state;
    if (func == FUNC_WRITE) begin
      case (addr_region(bus_address))
        RGN_BANK_LO: state_next.rom_bank = {state.rom_bank[BANK_W-1:BANK_LO_W], lo_bits};
        RGN_BANK_HI: begin
          state_next.rom_bank = {up_bits, state.rom_bank[BANK_LO_W-1:0]};
          if (state.bank_mode) begin
            state_next.zero_area_bank = {up_bits, {BANK_LO_W{1'b0}}};
          end
        end
        RGN_MODE:    state_next.bank_mode = write_data[0];
        default:     ;
      endcase
    end
  end

  // Hold bank state; advance on each processed transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      state.rom_bank       <= 7'd1;
      state.zero_area_bank <= '0;
      state.bank_mode      <= 1'b0;
    end else if (update) begin
      state <= state_next;
    end
  end

endmodule

@@ hdl/rbc_mapper.sv @@
`timescale 1ns / 1ps

module rbc_mapper #(
  parameter int unsigned ROM_OFFSET_BITS = rbc_pkg::ROM_OFFSET_BITS_DEF
) (
  input  rbc_pkg::bank_state_t           state,
  input  logic                           boot_rom_visible,
  input  logic                           func,
  input  logic [rbc_pkg::ADDR_W-1:0]     bus_address,
  output logic                           handled,
  output logic [rbc_pkg::OFFSET_W-1:0]   rom_offset
);
  import rbc_pkg::*;

  localparam logic [OFFSET_W-1:0] OFFSET_MASK =
    OFFSET_W'((64'd1 << ROM_OFFSET_BITS) - 64'd1);

  region_t rgn;
  logic [OFFSET_W-1:0] raw_offset;
  logic boot_hit;

  assign rgn      = addr_region(bus_address);
  assign boot_hit = boot_rom_visible && (bus_address < BOOT_END);

  // Bank number forms the high bits, in-bank address the low bits
  always_comb begin
    if (bus_address[BANK_SHIFT]) begin
      raw_offset = {state.rom_bank, bus_address[BANK_SHIFT-1:0]};
    end else if (state.bank_mode) begin
      raw_offset = {state.zero_area_bank, bus_address[BANK_SHIFT-1:0]};
    end else begin
      raw_offset = {{BANK_W{1'b0}}, bus_address[BANK_SHIFT-1:0]};
    end
  end

  // Decide interception and drive offset only for handled reads
  always_comb begin
    handled    = 1'b0;
    rom_offset = '0;
    if (func == FUNC_WRITE) begin
      handled = (rgn == RGN_BANK_LO) || (rgn == RGN_BANK_HI) || (rgn == RGN_MODE);
    end else if (!boot_hit && (rgn != RGN_OUTSIDE)) begin
      handled    = 1'b1;
      rom_offset = raw_offset & OFFSET_MASK;
    end
  end

endmodule

@@ hdl/rom_bank_controller_top.sv @@
`timescale 1ns / 1ps
// Pipeline: an accepted transaction is captured in the input register, then
// its result in the result register, which holds it for the master handshake.
// Throughput: one transaction per cycle unless m_tready stalls the result
// register; the bank registers are read and updated in the single compute
// stage between the input and result registers.
// Reset (rst, synchronous): both stages empty, rom_bank = 1,
// zero_area_bank = 0, ROM mode, rom_size_code = 0, boot_rom_visible = 1.

module rom_bank_controller_top #(
  parameter int unsigned ROM_OFFSET_BITS = rbc_pkg::ROM_OFFSET_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [rbc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [rbc_pkg::CFG_DATA_W-1:0]    cfg_data,
  // slave side
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [rbc_pkg::S_TDATA_W-1:0]     s_tdata,   // [15:0] bus_address, [23:16] write_data
  input  logic                              s_tuser,   // [0] func
  // master side
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [rbc_pkg::M_TDATA_W-1:0]     m_tdata,   // [20:0] rom_offset, [23:21] zero
  output logic                              m_tuser    // [0] handled
);
  import rbc_pkg::*;

  logic [SIZE_W-1:0]   rom_size_code;
  logic                boot_rom_visible;

  logic                in_valid;
  logic                in_func;
  logic [ADDR_W-1:0]   in_addr;
  logic [DATA_W-1:0]   in_data;

  logic                out_ready;
  logic                advance;
  bank_state_t         state;
  logic                handled;
  logic [OFFSET_W-1:0] rom_offset;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_size_code    <= '0;
      boot_rom_visible <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROM_SIZE: rom_size_code    <= cfg_data[SIZE_W-1:0];
        CFG_BOOT_VIS: boot_rom_visible <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  // Pipeline flow control
  assign out_ready = !m_tvalid || m_tready;
  assign advance   = in_valid && out_ready;
  assign s_tready  = !in_valid || out_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_func <= s_tuser;
      in_addr <= s_tdata[ADDR_W-1:0];
      in_data <= s_tdata[ADDR_W+DATA_W-1:ADDR_W];
    end
  end

  rbc_bank_regs u_bank_regs (
    .clk           (clk),
    .rst           (rst),
    .rom_size_code (rom_size_code),
    .update        (advance),
    .func          (in_func),
    .bus_address   (in_addr),
    .write_data    (in_data),
    .state         (state)
  );

  rbc_mapper #(
    .ROM_OFFSET_BITS (ROM_OFFSET_BITS)
  ) u_mapper (
    .state            (state),
    .boot_rom_visible (boot_rom_visible),
    .func             (in_func),
    .bus_address      (in_addr),
    .handled          (handled),
    .rom_offset       (rom_offset)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {{(M_TDATA_W-OFFSET_W){1'b0}}, rom_offset};
      m_tuser <= handled;
    end
  end

endmodule

@@ hdl/rbc_checker.sv @@
`timescale 1ns / 1ps

module rbc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [rbc_pkg::M_TDATA_W-1:0]  m_tdata,
  input logic                           m_tuser
);
  import rbc_pkg::*;

  // Stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // Unhandled access carries a zero offset
  a_unhandled_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("nonzero offset on unhandled access");

  // Padding above the offset stays clear
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[M_TDATA_W-1:OFFSET_W] == '0)
    else $error("padding bits set in result");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Empty pipeline always takes a transaction
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && !m_tvalid && $past(!s_tvalid || !s_tready) && $past(!m_tvalid)
    |-> s_tready)
    else $error("input stalled while pipeline empty");

endmodule

bind rom_bank_controller_top rbc_checker u_rbc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import rbc_pkg::*;

  // Bus regions of the cartridge window
  localparam logic [ADDR_W-1:0] LOW_BANK_BASE   = 16'h2000;
  localparam logic [ADDR_W-1:0] UPPER_BANK_BASE = 16'h4000;
  localparam logic [ADDR_W-1:0] MODE_BASE       = 16'h6000;
  localparam logic [ADDR_W-1:0] ROM_TOP         = 16'h7FFF;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 203;
  localparam int NUM_PHASES     = 8;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } bus_access_t;

  typedef struct packed {
    logic                handled;
    logic [OFFSET_W-1:0] offset;
  } rom_lookup_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_ROM_SIZE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic s_tuser = FUNC_READ;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic m_tuser;

  rom_bank_controller_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // Free-running clock, 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the controller configuration and bank state
  logic [SIZE_W-1:0] size_code = '0;
  logic              boot_visible = 1'b1;
  logic [BANK_W-1:0] rom_bank = 7'd1;
  logic [BANK_W-1:0] zero_area_bank = '0;
  logic              bank_mode = 1'b0;

  bus_access_t pending_accesses[$];
  rom_lookup_t predicted_lookups[$];
  int mismatch_count = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_req = 1'b0;

  // Apply one bus access to the shadow bank state and return its ROM lookup
  function automatic rom_lookup_t map_access(input bus_access_t a);
    rom_lookup_t r;
    logic [BANK_LO_W-1:0] lo_mask;
    logic [BANK_LO_W-1:0] lo_bits;
    logic [1:0] up_bits;
    r.handled = 1'b0;
    r.offset = '0;
    if (a.func == FUNC_WRITE) begin
      if (a.addr >= LOW_BANK_BASE && a.addr < UPPER_BANK_BASE) begin
        case (size_code)
          SIZE_64K:  lo_mask = 5'h03;
          SIZE_128K: lo_mask = 5'h07;
          SIZE_256K: lo_mask = 5'h0F;
          default:   lo_mask = 5'h1F;
        endcase
        // a zero low field selects bank one
        lo_bits = (a.data[4:0] == 5'd0) ? 5'd1 : (a.data[4:0] & lo_mask);
        rom_bank = {rom_bank[6:5], lo_bits};
        r.handled = 1'b1;
      end else if (a.addr >= UPPER_BANK_BASE && a.addr < MODE_BASE) begin
        if (size_code < SIZE_1M) begin
          up_bits = 2'b00;
        end else if (size_code < SIZE_2M) begin
          up_bits = {1'b0, a.data[0]};
        end else begin
          up_bits = a.data[1:0];
        end
        rom_bank = {up_bits, rom_bank[4:0]};
        if (bank_mode) begin
          zero_area_bank = {up_bits, 5'd0};
        end
        r.handled = 1'b1;
      end else if (a.addr >= MODE_BASE && a.addr <= ROM_TOP) begin
        bank_mode = a.data[0];
        r.handled = 1'b1;
      end
    end else begin
      if (boot_visible && a.addr < BOOT_END) begin
        r.handled = 1'b0;
      end else if (a.addr <= ROM_TOP) begin
        if (a.addr < UPPER_BANK_BASE) begin
          r.offset = bank_mode ? (OFFSET_W'(zero_area_bank) << BANK_SHIFT) : '0;
          r.offset = r.offset + OFFSET_W'(a.addr);
        end else begin
          r.offset = (OFFSET_W'(rom_bank) << BANK_SHIFT)
                   + OFFSET_W'(a.addr - UPPER_BANK_BASE);
        end
        r.handled = 1'b1;
      end
    end
    return r;
  endfunction

  // Mostly bank register writes and ROM reads, the rest anywhere on the bus
  function automatic bus_access_t random_access();
    bus_access_t a;
    int pick;
    pick = $urandom_range(99);
    a.data = DATA_W'($urandom_range(255));
    if (pick < 10) begin
      a.func = FUNC_READ;
      a.addr = ADDR_W'($urandom_range(16'h01FF));
    end else if (pick < 42) begin
      a.func = FUNC_READ;
      a.addr = ADDR_W'($urandom_range(ROM_TOP));
    end else if (pick < 77) begin
      a.func = FUNC_WRITE;
      a.addr = ADDR_W'($urandom_range(ROM_TOP, LOW_BANK_BASE));
      if ($urandom_range(3) == 0) begin
        a.data = a.data & 8'hE0;
      end
    end else begin
      a.func = 1'($urandom_range(1));
      a.addr = ADDR_W'($urandom_range(16'hFFFF));
    end
    return a;
  endfunction

  function automatic void add_access(input logic func, input logic [ADDR_W-1:0] addr,
                                     input logic [DATA_W-1:0] data);
    bus_access_t a;
    a.func = func;
    a.addr = addr;
    a.data = data;
    pending_accesses.push_back(a);
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch on %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $realtime);
    end
  endtask

  // Write one configuration register and mirror it in the shadow copy
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ROM_SIZE) begin
      size_code = val;
    end else begin
      boot_visible = val[0];
    end
  endtask

  // Wait until every queued access has been answered, then let the pipe settle
  task automatic drain();
    while (pending_accesses.size() != 0 || s_tvalid || predicted_lookups.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Driver: predict on acceptance, then offer the next pending access
  bus_access_t in_flight;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predicted_lookups.push_back(map_access(in_flight));
      end
      if (!s_tvalid || s_tready) begin
        if (pending_accesses.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_flight = pending_accesses.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {in_flight.data, in_flight.addr};
          s_tuser <= in_flight.func;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transaction, and throttle m_tready
  rom_lookup_t want;
  int hold_left = 0;
  logic hold_begun = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (predicted_lookups.size() == 0) begin
          note_mismatch("unexpected result", '0, 32'(m_tdata));
        end else begin
          want = predicted_lookups.pop_front();
          if (m_tuser !== want.handled) begin
            note_mismatch("handled", 32'(want.handled), 32'(m_tuser));
          end
          if (m_tdata[OFFSET_W-1:0] !== want.offset) begin
            note_mismatch("rom_offset", 32'(want.offset), 32'(m_tdata[OFFSET_W-1:0]));
          end
        end
      end
      // hold off long enough to back the block up into its input
      if (hold_req && !hold_begun) begin
        hold_begun <= 1'b1;
        hold_left <= HOLD_CYCLES;
        m_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  logic [SIZE_W-1:0] phase_size [NUM_PHASES] = '{SIZE_2M, 3'd0, SIZE_1M, 3'd7,
                                                 SIZE_64K, SIZE_128K, SIZE_256K, 3'd4};

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset configuration, boot overlay on, ROM size code 0
    add_access(FUNC_READ, 16'h0000, 8'h00);
    add_access(FUNC_READ, 16'h00FF, 8'h00);
    add_access(FUNC_READ, BOOT_END, 8'h00);
    add_access(FUNC_READ, UPPER_BANK_BASE, 8'h00);
    add_access(FUNC_WRITE, LOW_BANK_BASE, 8'h00);
    add_access(FUNC_WRITE, 16'h3FFF, 8'hFF);
    add_access(FUNC_READ, ROM_TOP, 8'h00);
    add_access(FUNC_WRITE, UPPER_BANK_BASE, 8'hFF);
    drain();

    // Directed: 2 MB ROM, top bank, RAM mode zero area, ignored writes
    write_reg(CFG_ROM_SIZE, SIZE_2M);
    write_reg(CFG_BOOT_VIS, 3'd1);
    add_access(FUNC_WRITE, 16'h5FFF, 8'hFF);
    add_access(FUNC_READ, ROM_TOP, 8'h00);
    add_access(FUNC_WRITE, MODE_BASE, 8'h01);
    add_access(FUNC_WRITE, UPPER_BANK_BASE, 8'h03);
    add_access(FUNC_READ, 16'h3FFF, 8'hFF);
    add_access(FUNC_READ, BOOT_END, 8'h00);
    add_access(FUNC_WRITE, ROM_TOP, 8'hFE);
    add_access(FUNC_WRITE, 16'h1FFF, 8'hFF);
    add_access(FUNC_WRITE, 16'hFFFF, 8'hFF);
    add_access(FUNC_READ, 16'h8000, 8'h00);
    add_access(FUNC_READ, 16'hFFFF, 8'hFF);
    add_access(FUNC_WRITE, LOW_BANK_BASE, 8'h20);
    drain();

    // Directed: boot overlay off, low addresses now mapped
    write_reg(CFG_BOOT_VIS, 3'd0);
    add_access(FUNC_READ, 16'h0000, 8'hFF);
    add_access(FUNC_READ, 16'h00FF, 8'h00);
    add_access(FUNC_READ, 16'h3FFF, 8'h00);
    drain();

    // Random phases over ROM sizes, overlay setting and idling pattern
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_ROM_SIZE, phase_size[p]);
      write_reg(CFG_BOOT_VIS, (p % 3 == 0) ? 3'd1 : 3'd0);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      if (p == 4) begin
        hold_req = 1'b1;
      end
      repeat (PHASE_ITEMS) pending_accesses.push_back(random_access());
      drain();
    end

    repeat (6) @(posedge clk);
    if (mismatch_count == 0 && predicted_lookups.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/rbc_pkg.sv
hdl/rbc_bank_regs.sv
hdl/rbc_mapper.sv
hdl/rom_bank_controller_top.sv
hdl/rbc_checker.sv
test/tb_top.sv
